// ===== hdl/tlsr_pkg.sv =====
package tlsr_pkg;

   localparam int COORD_BITS = 12;
   // Accepted coordinates are non-negative, so the line state keeps magnitudes only.
   localparam int MAG_BITS   = COORD_BITS - 1;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int THICK_BITS = 8;
   localparam int COLOR_BITS = 16;

   typedef enum logic {
      REQ_START   = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                          req_type;
      logic signed [COORD_BITS-1:0]  x_begin;
      logic signed [COORD_BITS-1:0]  y_begin;
      logic signed [COORD_BITS-1:0]  x_finish;
      logic signed [COORD_BITS-1:0]  y_finish;
      logic [THICK_BITS-1:0]         thickness;
      logic [COLOR_BITS-1:0]         pixel_color;
   } tlsr_request_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  rect_x;
      logic signed [COORD_BITS-1:0]  rect_y;
      logic [COORD_BITS-1:0]         rect_width;
      logic [COORD_BITS-1:0]         rect_height;
      logic [COLOR_BITS-1:0]         rect_color;
      logic                          last_rect;
   } tlsr_result_type;

endpackage

// ===== hdl/tlsr_core.sv =====
module tlsr_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  tlsr_pkg::tlsr_request_type req_payload,
   output logic                       res_valid,
   output tlsr_pkg::tlsr_result_type  res_payload
);
   import tlsr_pkg::*;

   typedef enum logic [1:0] {
      AXIS_WALK = 2'd0,
      AXIS_VERT = 2'd1,
      AXIS_HORZ = 2'd2
   } axis_type;

   logic                  line_active_ff, line_active_in;
   axis_type              axis_mode_ff, axis_mode_in;
   logic [MAG_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [MAG_BITS-1:0]   cur_row_ff, cur_row_in;
   logic [MAG_BITS-1:0]   end_col_ff, end_col_in;
   logic [MAG_BITS-1:0]   end_row_ff, end_row_in;
   logic [MAG_BITS-1:0]   delta_col_ff, delta_col_in;
   logic [MAG_BITS-1:0]   delta_row_ff, delta_row_in;
   logic [ERR_BITS-1:0]   error_term_ff, error_term_in;
   logic                  col_step_down_ff, col_step_down_in;
   logic                  row_step_down_ff, row_step_down_in;
   logic                  shallow_line_ff, shallow_line_in;
   logic [THICK_BITS-1:0] thick_value_ff, thick_value_in;
   logic [COLOR_BITS-1:0] line_color_ff, line_color_in;

   // Start decode.
   logic                  coord_negative;
   logic [MAG_BITS-1:0]   x1, y1, x2, y2, dx, dy;
   logic                  start_drop;

   // Walk step.
   logic [COORD_BITS-1:0] thick_ext, thick_plus1, half_ext;
   logic [COORD_BITS-1:0] col_ext, row_ext;
   logic                  walk_last;
   logic signed [ERR_BITS:0] err_x2, err_ext, dx_ext, dy_ext, err_sum;
   logic                  take_row, take_col;

   always_comb begin
      coord_negative = req_payload.x_begin[COORD_BITS-1] | req_payload.y_begin[COORD_BITS-1]
                     | req_payload.x_finish[COORD_BITS-1] | req_payload.y_finish[COORD_BITS-1];
      x1 = req_payload.x_begin[MAG_BITS-1:0];
      y1 = req_payload.y_begin[MAG_BITS-1:0];
      x2 = req_payload.x_finish[MAG_BITS-1:0];
      y2 = req_payload.y_finish[MAG_BITS-1:0];
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      start_drop = coord_negative
                 | (((dx == '0) | (dy == '0)) & (req_payload.thickness == '0));
   end

   always_comb begin
      thick_ext   = {{(COORD_BITS-THICK_BITS){1'b0}}, thick_value_ff};
      thick_plus1 = thick_ext + {{(COORD_BITS-1){1'b0}}, 1'b1};
      half_ext    = {{(COORD_BITS-THICK_BITS+1){1'b0}}, thick_value_ff[THICK_BITS-1:1]};
      col_ext     = {1'b0, cur_col_ff};
      row_ext     = {1'b0, cur_row_ff};
      walk_last   = (cur_col_ff == end_col_ff) & (cur_row_ff == end_row_ff);

      err_ext  = {error_term_ff[ERR_BITS-1], error_term_ff};
      err_x2   = {error_term_ff, 1'b0};
      dx_ext   = $signed({{(ERR_BITS+1-MAG_BITS){1'b0}}, delta_col_ff});
      dy_ext   = $signed({{(ERR_BITS+1-MAG_BITS){1'b0}}, delta_row_ff});
      take_row = err_x2 < dx_ext;
      take_col = err_x2 > -dy_ext;
      err_sum  = err_ext + (take_row ? dx_ext : '0) - (take_col ? dy_ext : '0);
   end

   always_comb begin
      line_active_in   = line_active_ff;
      axis_mode_in     = axis_mode_ff;
      cur_col_in       = cur_col_ff;
      cur_row_in       = cur_row_ff;
      end_col_in       = end_col_ff;
      end_row_in       = end_row_ff;
      delta_col_in     = delta_col_ff;
      delta_row_in     = delta_row_ff;
      error_term_in    = error_term_ff;
      col_step_down_in = col_step_down_ff;
      row_step_down_in = row_step_down_ff;
      shallow_line_in  = shallow_line_ff;
      thick_value_in   = thick_value_ff;
      line_color_in    = line_color_ff;

      res_valid               = 1'b0;
      res_payload.rect_x      = $signed(col_ext);
      res_payload.rect_y      = $signed(row_ext);
      res_payload.rect_width  = thick_ext;
      res_payload.rect_height = thick_ext;
      res_payload.rect_color  = line_color_ff;
      res_payload.last_rect   = 1'b1;

      if (req_fire) begin
         case (req_payload.req_type)
            REQ_START: begin
               if (!start_drop) begin
                  line_active_in   = 1'b1;
                  thick_value_in   = req_payload.thickness;
                  line_color_in    = req_payload.pixel_color;
                  delta_col_in     = dx;
                  delta_row_in     = dy;
                  col_step_down_in = x2 < x1;
                  row_step_down_in = y2 < y1;
                  shallow_line_in  = dx >= dy;
                  end_col_in       = x2;
                  end_row_in       = y2;
                  error_term_in    = {{(ERR_BITS-MAG_BITS){1'b0}}, dx}
                                   - {{(ERR_BITS-MAG_BITS){1'b0}}, dy};
                  if (dx == '0) begin
                     axis_mode_in = AXIS_VERT;
                     cur_col_in   = x1;
                     cur_row_in   = (y1 < y2) ? y1 : y2;
                  end else if (dy == '0) begin
                     axis_mode_in = AXIS_HORZ;
                     cur_col_in   = (x1 < x2) ? x1 : x2;
                     cur_row_in   = y1;
                  end else begin
                     axis_mode_in = AXIS_WALK;
                     cur_col_in   = x1;
                     cur_row_in   = y1;
                  end
               end
            end
            REQ_ADVANCE: begin
               if (line_active_ff) begin
                  res_valid = 1'b1;
                  case (axis_mode_ff)
                     AXIS_VERT: begin
                        res_payload.rect_height = {1'b0, delta_row_ff}
                                                + {{(COORD_BITS-1){1'b0}}, 1'b1};
                        line_active_in = 1'b0;
                     end
                     AXIS_HORZ: begin
                        res_payload.rect_width = {1'b0, delta_col_ff}
                                               + {{(COORD_BITS-1){1'b0}}, 1'b1};
                        line_active_in = 1'b0;
                     end
                     default: begin
                        res_payload.last_rect = walk_last;
                        if (shallow_line_ff) begin
                           res_payload.rect_y      = $signed(row_ext - half_ext);
                           res_payload.rect_width  = {{(COORD_BITS-1){1'b0}}, 1'b1};
                           res_payload.rect_height = thick_plus1;
                        end else begin
                           res_payload.rect_x      = $signed(col_ext - half_ext);
                           res_payload.rect_width  = thick_plus1;
                           res_payload.rect_height = {{(COORD_BITS-1){1'b0}}, 1'b1};
                        end
                        if (walk_last) begin
                           line_active_in = 1'b0;
                        end else begin
                           error_term_in = err_sum[ERR_BITS-1:0];
                           if (take_row) begin
                              cur_row_in = row_step_down_ff
                                 ? cur_row_ff - {{(MAG_BITS-1){1'b0}}, 1'b1}
                                 : cur_row_ff + {{(MAG_BITS-1){1'b0}}, 1'b1};
                           end
                           if (take_col) begin
                              cur_col_in = col_step_down_ff
                                 ? cur_col_ff - {{(MAG_BITS-1){1'b0}}, 1'b1}
                                 : cur_col_ff + {{(MAG_BITS-1){1'b0}}, 1'b1};
                           end
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         axis_mode_ff   <= AXIS_WALK;
      end else begin
         line_active_ff <= line_active_in;
         axis_mode_ff   <= axis_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff       <= cur_col_in;
      cur_row_ff       <= cur_row_in;
      end_col_ff       <= end_col_in;
      end_row_ff       <= end_row_in;
      delta_col_ff     <= delta_col_in;
      delta_row_ff     <= delta_row_in;
      error_term_ff    <= error_term_in;
      col_step_down_ff <= col_step_down_in;
      row_step_down_ff <= row_step_down_in;
      shallow_line_ff  <= shallow_line_in;
      thick_value_ff   <= thick_value_in;
      line_color_ff    <= line_color_in;
   end

endmodule

// ===== hdl/tlsr_out_buf.sv =====
module tlsr_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   input  tlsr_pkg::tlsr_result_type res_payload,
   output logic                      buf_full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlsr_pkg::tlsr_result_type rsp_payload
);
   import tlsr_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   tlsr_result_type out_data_ff, out_data_in;
   tlsr_result_type skid_data_ff, skid_data_in;
   logic            drain;

   // The skid entry catches one result while the receiver stalls, so the
   // request side only stalls once both entries are occupied.
   always_comb begin
      drain         = out_valid_ff & ~rsp_stall;
      out_valid_in  = out_valid_ff & ~drain;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (!out_valid_in) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = res_payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign buf_full    = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

// ===== hdl/thick_line_span_rasterizer_top.sv =====
// Thick line span rasterizer.
// Requests arrive on req_valid / req_stall / req_payload. A start request
// loads a line (endpoints, thickness, color); each advance request returns
// the next rectangle to fill on rsp_valid / rsp_stall / rsp_payload, with
// last_rect set on the final one. Start requests, dropped starts and
// advances while no line is active produce no response.
// The response to an accepted advance request is registered in the response
// register, or in the skid entry while that register is held. Throughput: one
// request per cycle while req_stall is low, set by the single add-and-compare
// error step between the line state registers and the response register.
// Reset clears the active line and both response entries; the block takes
// requests in the first cycle after reset.
// When the receiver stalls, the response register holds its value and one
// more response is caught in a skid entry; req_stall rises while that
// entry is occupied and falls as soon as the receiver drains it.
module thick_line_span_rasterizer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tlsr_pkg::tlsr_request_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tlsr_pkg::tlsr_result_type  rsp_payload
);
   import tlsr_pkg::*;

   logic            req_fire;
   logic            res_valid;
   tlsr_result_type res_payload;
   logic            buf_full;

   assign req_stall = buf_full;
   assign req_fire  = req_valid & ~buf_full;

   tlsr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_payload (res_payload)
   );

   tlsr_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_payload (res_payload),
      .buf_full    (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
